// ===== src/a64enc_pkg.sv =====
package a64enc_pkg;

  // Operation codes of the instruction record. Ranges are named by their first and last code.
  localparam logic [5:0] OP_HALT        = 6'd0;
  localparam logic [5:0] OP_ARITH_FIRST = 6'd1;
  localparam logic [5:0] OP_ARITH_LAST  = 6'd4;
  localparam logic [5:0] OP_MOVE_FIRST  = 6'd5;
  localparam logic [5:0] OP_MOVE_LAST   = 6'd7;
  localparam logic [5:0] OP_ALU_FIRST   = 6'd8;
  localparam logic [5:0] OP_ALU_LAST    = 6'd19;
  localparam logic [5:0] OP_MADD        = 6'd20;
  localparam logic [5:0] OP_MSUB        = 6'd21;
  localparam logic [5:0] OP_LDST        = 6'd22;
  localparam logic [5:0] OP_LDR_LIT     = 6'd23;
  localparam logic [5:0] OP_BCOND_FIRST = 6'd24;
  localparam logic [5:0] OP_BCOND_LAST  = 6'd30;
  localparam logic [5:0] OP_B           = 6'd31;
  localparam logic [5:0] OP_BR          = 6'd32;
  localparam logic [5:0] OP_DATA        = 6'd33;

  // Fixed bit patterns of each instruction class.
  localparam logic [31:0] WORD_HALT     = 32'h8A00_0000;
  localparam logic [31:0] BASE_ARITH    = 32'h1100_0000;
  localparam logic [31:0] BASE_MOVE     = 32'h1280_0000;
  localparam logic [31:0] BASE_ALU      = 32'h0A00_0000;
  localparam logic [31:0] BASE_MUL      = 32'h1B00_0000;
  localparam logic [31:0] BASE_LDST     = 32'hB800_0000;
  localparam logic [31:0] BASE_LDR_LIT  = 32'h1800_0000;
  localparam logic [31:0] BASE_BCOND    = 32'h5400_0000;
  localparam logic [31:0] BASE_B        = 32'h1400_0000;
  localparam logic [31:0] BASE_BR       = 32'hD61F_0000;
  localparam logic [5:0]  LDST_REG_OPT  = 6'h1A;

  // Beat widths on the stream ports.
  localparam int unsigned InDataW  = 64;
  localparam int unsigned InUserW  = 6;
  localparam int unsigned OutDataW = 32;
  localparam int unsigned OutUserW = 1;

  typedef enum logic [1:0] {
    AM_UNSIGNED = 2'd0,
    AM_REGISTER = 2'd1,
    AM_PRE      = 2'd2,
    AM_POST     = 2'd3
  } addr_mode_e;

  // One assembled-instruction record.
  typedef struct packed {
    logic [5:0]  opcode;
    logic        wide;
    logic [4:0]  dest_reg;
    logic [4:0]  base_reg;
    logic [4:0]  second_reg;
    logic [4:0]  accum_reg;
    logic [31:0] immediate;
    logic [1:0]  shift_type;
    logic        shift_twelve;
    logic [1:0]  half_select;
    addr_mode_e  addr_mode;
    logic        is_load;
  } a64enc_instr_t;

  typedef struct packed {
    logic [31:0] machine_word;
    logic        bad_opcode;
  } a64enc_result_t;

  // opc field of movn, movz and movk.
  function automatic logic [1:0] move_opc(input logic [1:0] idx);
    logic [1:0] opc;
    unique case (idx)
      2'd0:    opc = 2'd0;
      2'd1:    opc = 2'd2;
      2'd2:    opc = 2'd3;
      default: opc = 2'd0;
    endcase
    return opc;
  endfunction

  // Condition code for b.eq, b.ne, b.ge, b.lt, b.gt, b.le and b.al in that order.
  function automatic logic [3:0] cond_code(input logic [2:0] idx);
    logic [3:0] cond;
    unique case (idx)
      3'd0:    cond = 4'h0;
      3'd1:    cond = 4'h1;
      3'd2:    cond = 4'hA;
      3'd3:    cond = 4'hB;
      3'd4:    cond = 4'hC;
      3'd5:    cond = 4'hD;
      3'd6:    cond = 4'hE;
      default: cond = 4'h0;
    endcase
    return cond;
  endfunction

endpackage

// ===== src/a64enc_pack.sv =====
module a64enc_pack import a64enc_pkg::*; (
  input  a64enc_instr_t  instr_i,
  output a64enc_result_t result_o
);

  logic [3:0]  alu_idx;
  logic [2:0]  logic_idx;
  logic [1:0]  alu_opc;
  logic [3:0]  alu_opr;
  logic [31:0] arith_w;
  logic [31:0] move_w;
  logic [31:0] alu_w;
  logic [31:0] mul_w;
  logic [31:0] ldst_w;
  logic [31:0] lit_w;
  logic [31:0] bcond_w;
  logic [31:0] regs_w;

  // Register fields shared by the add/sub, ALU, multiply and load/store classes.
  assign regs_w = {22'd0, instr_i.base_reg, instr_i.dest_reg};

  // Add/sub immediate.
  assign arith_w = BASE_ARITH | {instr_i.wide, 2'(instr_i.opcode[1:0] - 2'd1), 6'd0,
                   instr_i.shift_twelve, instr_i.immediate[11:0], 10'd0} | regs_w;

  // Wide moves.
  assign move_w = BASE_MOVE | {instr_i.wide, move_opc(2'(instr_i.opcode - OP_MOVE_FIRST)),
                  6'd0, instr_i.half_select, instr_i.immediate[15:0], instr_i.dest_reg};

  // Shifted-register arithmetic sets the top option bit; logic ops take N from the code.
  always_comb begin
    alu_idx   = 4'(instr_i.opcode - OP_ALU_FIRST);
    logic_idx = 3'(alu_idx - 4'd4);
    if (alu_idx < 4'd4) begin
      alu_opc = alu_idx[1:0];
      alu_opr = {1'b1, instr_i.shift_type, 1'b0};
    end else begin
      alu_opc = logic_idx[2:1];
      alu_opr = {1'b0, instr_i.shift_type, logic_idx[0]};
    end
  end

  assign alu_w = BASE_ALU | {instr_i.wide, alu_opc, 4'd0, alu_opr, instr_i.second_reg,
                 instr_i.immediate[5:0], 10'd0} | regs_w;

  // Multiply-add and multiply-subtract.
  assign mul_w = BASE_MUL | {instr_i.wide, 10'd0, instr_i.second_reg,
                 (instr_i.opcode == OP_MSUB), instr_i.accum_reg, 10'd0} | regs_w;

  // Single-register load/store in its four addressing modes.
  always_comb begin
    ldst_w = BASE_LDST | {1'b0, instr_i.wide, 7'd0, instr_i.is_load, 22'd0} | regs_w;
    unique case (instr_i.addr_mode)
      AM_UNSIGNED: ldst_w = ldst_w | {7'd0, 1'b1, 2'd0, instr_i.immediate[11:0], 10'd0};
      AM_REGISTER: ldst_w = ldst_w | {10'd0, 1'b1, instr_i.second_reg, LDST_REG_OPT, 10'd0};
      AM_PRE:      ldst_w = ldst_w | {11'd0, instr_i.immediate[8:0], 2'b11, 10'd0};
      AM_POST:     ldst_w = ldst_w | {11'd0, instr_i.immediate[8:0], 2'b01, 10'd0};
      default:     ldst_w = ldst_w;
    endcase
  end

  assign lit_w = BASE_LDR_LIT | {1'b0, instr_i.wide, 6'd0, instr_i.immediate[18:0],
                 instr_i.dest_reg};

  assign bcond_w = BASE_BCOND | {8'd0, instr_i.immediate[18:0], 1'b0,
                   cond_code(3'(instr_i.opcode - OP_BCOND_FIRST))};

  // Class select by operation code.
  always_comb begin
    result_o.bad_opcode = 1'b0;
    priority if (instr_i.opcode == OP_HALT) begin
      result_o.machine_word = WORD_HALT;
    end else if (instr_i.opcode <= OP_ARITH_LAST) begin
      result_o.machine_word = arith_w;
    end else if (instr_i.opcode <= OP_MOVE_LAST) begin
      result_o.machine_word = move_w;
    end else if (instr_i.opcode <= OP_ALU_LAST) begin
      result_o.machine_word = alu_w;
    end else if (instr_i.opcode <= OP_MSUB) begin
      result_o.machine_word = mul_w;
    end else if (instr_i.opcode == OP_LDST) begin
      result_o.machine_word = ldst_w;
    end else if (instr_i.opcode == OP_LDR_LIT) begin
      result_o.machine_word = lit_w;
    end else if (instr_i.opcode <= OP_BCOND_LAST) begin
      result_o.machine_word = bcond_w;
    end else if (instr_i.opcode == OP_B) begin
      result_o.machine_word = BASE_B | {6'd0, instr_i.immediate[25:0]};
    end else if (instr_i.opcode == OP_BR) begin
      result_o.machine_word = BASE_BR | {22'd0, instr_i.base_reg, 5'd0};
    end else if (instr_i.opcode == OP_DATA) begin
      result_o.machine_word = instr_i.immediate;
    end else begin
      result_o.machine_word = '0;
      result_o.bad_opcode   = 1'b1;
    end
  end

endmodule

// ===== src/a64_subset_instruction_encoder.sv =====
// Packs one assembled-instruction record per beat into a 32-bit A64 machine word. Each
// record passes an input register, one level of packing logic and a result register, so a
// result is offered on the output once it has passed both registers, and one record per
// cycle is sustained while the output takes results.
// The input port stalls only when both registers hold beats and the output is not taken.
// Unknown operation codes give word zero with tuser set.
module a64_subset_instruction_encoder import a64enc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // Fields from bit 0: wide, dest_reg, base_reg, second_reg, accum_reg, immediate,
  // shift_type, shift_twelve, half_select, addr_mode, is_load, zero fill.
  input  logic [InDataW-1:0]  s_axis_tdata,
  // Fields from bit 0: opcode.
  input  logic [InUserW-1:0]  s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // Fields from bit 0: machine_word.
  output logic [OutDataW-1:0] m_axis_tdata,
  // Fields from bit 0: bad_opcode.
  output logic [OutUserW-1:0] m_axis_tuser
);

  a64enc_instr_t  instr_d, instr_q;
  a64enc_result_t result_d, result_q;
  logic           in_valid_q;
  logic           out_valid_q;
  logic           advance;
  logic           s_accept;

  // The result register frees when empty or taken; the input register then moves on.
  assign advance       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || advance;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  // Unpack the incoming beat.
  always_comb begin
    instr_d.opcode       = s_axis_tuser;
    instr_d.wide         = s_axis_tdata[0];
    instr_d.dest_reg     = s_axis_tdata[5:1];
    instr_d.base_reg     = s_axis_tdata[10:6];
    instr_d.second_reg   = s_axis_tdata[15:11];
    instr_d.accum_reg    = s_axis_tdata[20:16];
    instr_d.immediate    = s_axis_tdata[52:21];
    instr_d.shift_type   = s_axis_tdata[54:53];
    instr_d.shift_twelve = s_axis_tdata[55];
    instr_d.half_select  = s_axis_tdata[57:56];
    instr_d.addr_mode    = addr_mode_e'(s_axis_tdata[59:58]);
    instr_d.is_load      = s_axis_tdata[60];
  end

  // Input register valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  // Input register payload.
  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      instr_q <= instr_d;
    end
  end

  a64enc_pack u_pack (
    .instr_i  (instr_q),
    .result_o (result_d)
  );

  // Result register valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  // Result register payload.
  always_ff @(posedge clk_i) begin
    if (advance && in_valid_q) begin
      result_q <= result_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = result_q.machine_word;
  assign m_axis_tuser  = result_q.bad_opcode;

  // A flagged result always carries word zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0)
    else $error("bad opcode result with nonzero word");

  // A held record is not dropped while the result side stalls.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q && out_valid_q)
    else $error("record lost during stall");

  // The input side stalls only when both registers are full.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> in_valid_q && out_valid_q)
    else $error("input stalled with a free register");

  // An accepted beat lands in the input register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_accept |=> in_valid_q)
    else $error("accepted beat not captured");

endmodule

// ===== verif/tb_a64_subset_instruction_encoder.sv =====
module tb_a64_subset_instruction_encoder import a64enc_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam time         CLK_PERIOD     = 20ns;
  localparam int unsigned RESET_CYCLES   = 8;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned DRAIN_SLACK    = 10;
  localparam int unsigned PRINT_CAP      = 30;

  // Codes beyond the last defined operation.
  localparam logic [5:0] OP_FIRST_UNKNOWN = OP_DATA + 6'd1;
  localparam logic [5:0] OP_LAST_CODE     = 6'd63;

  // opc values of the wide moves.
  localparam logic [1:0] MOVN_OPC = 2'd0;
  localparam logic [1:0] MOVZ_OPC = 2'd2;
  localparam logic [1:0] MOVK_OPC = 2'd3;

  // Condition field of the conditional branches.
  localparam logic [3:0] COND_EQ = 4'h0;
  localparam logic [3:0] COND_NE = 4'h1;
  localparam logic [3:0] COND_GE = 4'hA;
  localparam logic [3:0] COND_LT = 4'hB;
  localparam logic [3:0] COND_GT = 4'hC;
  localparam logic [3:0] COND_LE = 4'hD;
  localparam logic [3:0] COND_AL = 4'hE;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;
  logic [InUserW-1:0]  s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic [OutUserW-1:0] m_axis_tuser;

  // Record currently offered on the input.
  a64enc_instr_t src_instr = '0;

  // Words still owed by the block, oldest first.
  a64enc_result_t pending_words[$];

  int unsigned mismatch_count = 0;
  int unsigned result_count   = 0;
  int unsigned idle_cycles    = 0;
  int unsigned in_stalls      = 0;
  int unsigned out_stalls     = 0;
  int unsigned opcode_seen[64];

  // Output side control: random hold-offs, and one long hold per token change.
  logic        sink_bursty = 1'b0;
  int unsigned hold_token  = 0;
  int unsigned hold_seen   = 0;
  int unsigned sink_wait   = 0;

  a64enc_result_t want;
  logic           progress;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Fields from bit 0: wide, dest_reg, base_reg, second_reg, accum_reg, immediate,
  // shift_type, shift_twelve, half_select, addr_mode, is_load, zero fill.
  assign s_axis_tdata = {3'b000, src_instr.is_load, src_instr.addr_mode,
                         src_instr.half_select, src_instr.shift_twelve,
                         src_instr.shift_type, src_instr.immediate, src_instr.accum_reg,
                         src_instr.second_reg, src_instr.base_reg, src_instr.dest_reg,
                         src_instr.wide};
  // Fields from bit 0: opcode.
  assign s_axis_tuser = src_instr.opcode;

  a64_subset_instruction_encoder u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Packs one record into its machine word the way the instruction set lays it out.
  function automatic a64enc_result_t encode_instr(input a64enc_instr_t ins);
    a64enc_result_t res;
    logic [31:0]    w;
    logic [5:0]     op;
    logic [3:0]     alu_idx;
    logic [2:0]     logic_idx;
    op             = ins.opcode;
    w              = '0;
    res.bad_opcode = 1'b0;
    if (op == OP_HALT) begin
      w = WORD_HALT;
    end else if (op <= OP_ARITH_LAST) begin
      w          = BASE_ARITH;
      w[31]      = ins.wide;
      w[30:29]   = 2'(op - OP_ARITH_FIRST);
      w[22]      = ins.shift_twelve;
      w[21:10]   = ins.immediate[11:0];
      w[9:5]     = ins.base_reg;
      w[4:0]     = ins.dest_reg;
    end else if (op <= OP_MOVE_LAST) begin
      w        = BASE_MOVE;
      w[31]    = ins.wide;
      if (op == OP_MOVE_FIRST) begin
        w[30:29] = MOVN_OPC;
      end else if (op == OP_MOVE_FIRST + 6'd1) begin
        w[30:29] = MOVZ_OPC;
      end else begin
        w[30:29] = MOVK_OPC;
      end
      w[22:21] = ins.half_select;
      w[20:5]  = ins.immediate[15:0];
      w[4:0]   = ins.dest_reg;
    end else if (op <= OP_ALU_LAST) begin
      // The first four are add/sub with bit 24 set; the logic group carries N in bit 21.
      alu_idx  = 4'(op - OP_ALU_FIRST);
      w        = BASE_ALU;
      w[31]    = ins.wide;
      w[23:22] = ins.shift_type;
      if (alu_idx < 4'd4) begin
        w[30:29] = alu_idx[1:0];
        w[24]    = 1'b1;
      end else begin
        logic_idx = 3'(alu_idx - 4'd4);
        w[30:29]  = logic_idx[2:1];
        w[21]     = logic_idx[0];
      end
      w[20:16] = ins.second_reg;
      w[15:10] = ins.immediate[5:0];
      w[9:5]   = ins.base_reg;
      w[4:0]   = ins.dest_reg;
    end else if (op <= OP_MSUB) begin
      w        = BASE_MUL;
      w[31]    = ins.wide;
      w[20:16] = ins.second_reg;
      w[15]    = (op == OP_MSUB);
      w[14:10] = ins.accum_reg;
      w[9:5]   = ins.base_reg;
      w[4:0]   = ins.dest_reg;
    end else if (op == OP_LDST) begin
      w     = BASE_LDST;
      w[30] = ins.wide;
      w[22] = ins.is_load;
      case (ins.addr_mode)
        AM_UNSIGNED: begin
          w[24]    = 1'b1;
          w[21:10] = ins.immediate[11:0];
        end
        AM_REGISTER: begin
          w[21]    = 1'b1;
          w[20:16] = ins.second_reg;
          w[15:10] = LDST_REG_OPT;
        end
        default: begin
          w[20:12] = ins.immediate[8:0];
          w[11]    = (ins.addr_mode == AM_PRE);
          w[10]    = 1'b1;
        end
      endcase
      w[9:5] = ins.base_reg;
      w[4:0] = ins.dest_reg;
    end else if (op == OP_LDR_LIT) begin
      w       = BASE_LDR_LIT;
      w[30]   = ins.wide;
      w[23:5] = ins.immediate[18:0];
      w[4:0]  = ins.dest_reg;
    end else if (op <= OP_BCOND_LAST) begin
      w       = BASE_BCOND;
      w[23:5] = ins.immediate[18:0];
      case (op - OP_BCOND_FIRST)
        6'd0:    w[3:0] = COND_EQ;
        6'd1:    w[3:0] = COND_NE;
        6'd2:    w[3:0] = COND_GE;
        6'd3:    w[3:0] = COND_LT;
        6'd4:    w[3:0] = COND_GT;
        6'd5:    w[3:0] = COND_LE;
        default: w[3:0] = COND_AL;
      endcase
    end else if (op == OP_B) begin
      w       = BASE_B;
      w[25:0] = ins.immediate[25:0];
    end else if (op == OP_BR) begin
      w      = BASE_BR;
      w[9:5] = ins.base_reg;
    end else if (op == OP_DATA) begin
      w = ins.immediate;
    end else begin
      res.bad_opcode = 1'b1;
    end
    res.machine_word = w;
    return res;
  endfunction

  function automatic a64enc_instr_t instr_of(
    input logic [5:0]  op,
    input logic        wide,
    input logic [4:0]  rd,
    input logic [4:0]  rn,
    input logic [4:0]  rm,
    input logic [4:0]  ra,
    input logic [31:0] imm,
    input logic [1:0]  shift,
    input logic        sh,
    input logic [1:0]  hw,
    input addr_mode_e  mode,
    input logic        ld
  );
    a64enc_instr_t ins;
    ins.opcode       = op;
    ins.wide         = wide;
    ins.dest_reg     = rd;
    ins.base_reg     = rn;
    ins.second_reg   = rm;
    ins.accum_reg    = ra;
    ins.immediate    = imm;
    ins.shift_type   = shift;
    ins.shift_twelve = sh;
    ins.half_select  = hw;
    ins.addr_mode    = mode;
    ins.is_load      = ld;
    return ins;
  endfunction

  // Mostly defined operations, with an eighth of unknown codes mixed in.
  function automatic a64enc_instr_t rand_instr();
    a64enc_instr_t ins;
    if ($urandom_range(0, 7) == 0) begin
      ins.opcode = 6'($urandom_range(OP_FIRST_UNKNOWN, OP_LAST_CODE));
    end else begin
      ins.opcode = 6'($urandom_range(OP_HALT, OP_DATA));
    end
    ins.wide       = 1'($urandom());
    ins.dest_reg   = 5'($urandom());
    ins.base_reg   = 5'($urandom());
    ins.second_reg = 5'($urandom());
    ins.accum_reg  = 5'($urandom());
    // Small offsets, small negative offsets, all ones and full random words.
    case ($urandom_range(0, 3))
      0:       ins.immediate = $urandom();
      1:       ins.immediate = $urandom_range(0, 511);
      2:       ins.immediate = '1;
      default: ins.immediate = ~$urandom_range(0, 511);
    endcase
    ins.shift_type   = 2'($urandom());
    ins.shift_twelve = 1'($urandom());
    ins.half_select  = 2'($urandom());
    ins.addr_mode    = addr_mode_e'($urandom_range(0, 3));
    ins.is_load      = 1'($urandom());
    return ins;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 75) begin
      return $urandom_range(1, 3);
    end else if (r < 95) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 80);
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] exp_val,
                                 input logic [31:0] got_val);
    // Keep the log short when the block is badly broken.
    if (mismatch_count < PRINT_CAP) begin
      $display("[%0t] result %0d: %s, expected %h, got %h", $realtime, result_count, what,
               exp_val, got_val);
    end
    mismatch_count++;
  endtask

  // Offer one record and hold it until the block takes the beat.
  task automatic send_instr(input a64enc_instr_t ins);
    src_instr     <= ins;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic idle_source(input int unsigned cycles);
    s_axis_tvalid <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // Stop offering until every owed word has come back.
  task automatic wait_all_results();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (pending_words.size() != 0);
    @(posedge clk_i);
  endtask

  // Output side: either always ready, randomly stalling, or one long hold on request.
  always @(posedge clk_i) begin
    if (hold_seen != hold_token) begin
      hold_seen     = hold_token;
      sink_wait     = HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (sink_wait != 0) begin
      sink_wait     = sink_wait - 1;
      m_axis_tready <= 1'b0;
    end else if (sink_bursty && $urandom_range(0, 3) == 0) begin
      sink_wait     = gap_len() - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Record accepted inputs first, then check the result beat of the same edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      progress = 1'b0;
      if (s_axis_tvalid && s_axis_tready) begin
        pending_words.push_back(encode_instr(src_instr));
        opcode_seen[src_instr.opcode]++;
        progress = 1'b1;
      end
      if (s_axis_tvalid && !s_axis_tready) in_stalls++;
      if (m_axis_tvalid && !m_axis_tready) out_stalls++;
      if (m_axis_tvalid && m_axis_tready) begin
        progress = 1'b1;
        if (pending_words.size() == 0) begin
          report_mismatch("word with no record outstanding", '0, m_axis_tdata);
        end else begin
          want = pending_words.pop_front();
          if (m_axis_tdata !== want.machine_word) begin
            report_mismatch("machine_word", want.machine_word, m_axis_tdata);
          end
          if (m_axis_tuser[0] !== want.bad_opcode) begin
            report_mismatch("bad_opcode", 32'(want.bad_opcode), 32'(m_axis_tuser));
          end
        end
        result_count++;
      end
      idle_cycles = progress ? 0 : idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog: no beat moved for %0d cycles, %0d words outstanding",
                 WATCHDOG_LIMIT, pending_words.size());
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // Extremes of every field, each operation class, cut immediates, the reserved shift
  // and unknown codes.
  task automatic test_directed();
    sink_bursty <= 1'b0;
    send_instr(instr_of(OP_HALT, 0, 0, 0, 0, 0, '0, 0, 0, 0, AM_UNSIGNED, 0));
    send_instr(instr_of(OP_ARITH_FIRST, 1, 31, 31, 31, 31, '1, 3, 1, 3, AM_POST, 1));
    send_instr(instr_of(OP_ARITH_LAST, 0, 0, 31, 0, 0, 32'hFFFF_F000, 0, 0, 0,
                        AM_UNSIGNED, 0));
    send_instr(instr_of(OP_MOVE_FIRST, 1, 31, 0, 0, 0, '1, 0, 0, 3, AM_UNSIGNED, 0));
    send_instr(instr_of(OP_MOVE_FIRST + 6'd1, 0, 7, 31, 31, 31, 32'hFFFF_0000, 3, 1, 0,
                        AM_PRE, 1));
    send_instr(instr_of(OP_MOVE_LAST, 1, 16, 0, 0, 0, 32'h0001_8001, 0, 0, 2,
                        AM_UNSIGNED, 0));
    send_instr(instr_of(OP_ALU_FIRST, 1, 31, 31, 31, 31, '1, 3, 1, 3, AM_POST, 1));
    send_instr(instr_of(OP_ALU_FIRST + 6'd4, 0, 1, 2, 3, 4, 32'hFFFF_FFC0, 2, 0, 0,
                        AM_UNSIGNED, 0));
    send_instr(instr_of(OP_ALU_FIRST + 6'd9, 1, 10, 20, 30, 0, 32'h0000_0015, 1, 0, 1,
                        AM_REGISTER, 0));
    send_instr(instr_of(OP_ALU_LAST, 1, 31, 31, 31, 31, '1, 3, 1, 3, AM_POST, 1));
    send_instr(instr_of(OP_MADD, 1, 31, 31, 31, 31, '1, 3, 1, 3, AM_POST, 1));
    send_instr(instr_of(OP_MSUB, 0, 0, 0, 0, 0, '0, 0, 0, 0, AM_UNSIGNED, 0));
    send_instr(instr_of(OP_LDST, 1, 31, 31, 31, 31, '1, 3, 1, 3, AM_UNSIGNED, 1));
    send_instr(instr_of(OP_LDST, 0, 5, 6, 31, 0, '1, 0, 0, 0, AM_REGISTER, 0));
    send_instr(instr_of(OP_LDST, 1, 1, 2, 0, 0, 32'h0000_01FF, 0, 0, 0, AM_PRE, 1));
    send_instr(instr_of(OP_LDST, 0, 0, 0, 0, 0, 32'hFFFF_FE00, 0, 0, 0, AM_POST, 0));
    send_instr(instr_of(OP_LDR_LIT, 1, 31, 31, 31, 31, '1, 3, 1, 3, AM_POST, 1));
    send_instr(instr_of(OP_BCOND_FIRST, 0, 0, 0, 0, 0, 32'h0007_FFFF, 0, 0, 0,
                        AM_UNSIGNED, 0));
    send_instr(instr_of(OP_BCOND_LAST, 1, 31, 31, 31, 31, 32'hFFF8_0000, 3, 1, 3,
                        AM_POST, 1));
    send_instr(instr_of(OP_B, 1, 31, 31, 31, 31, '1, 3, 1, 3, AM_POST, 1));
    send_instr(instr_of(OP_BR, 1, 31, 31, 31, 31, '1, 3, 1, 3, AM_POST, 1));
    send_instr(instr_of(OP_DATA, 0, 0, 0, 0, 0, '1, 0, 0, 0, AM_UNSIGNED, 0));
    send_instr(instr_of(OP_DATA, 1, 31, 31, 31, 31, '0, 3, 1, 3, AM_POST, 1));
    send_instr(instr_of(OP_FIRST_UNKNOWN, 1, 31, 31, 31, 31, '1, 3, 1, 3, AM_POST, 1));
    send_instr(instr_of(OP_LAST_CODE, 1, 31, 31, 31, 31, '1, 3, 1, 3, AM_POST, 1));
    wait_all_results();
  endtask

  // Random records in segments; each segment picks its own idling on both sides.
  task automatic test_random_mix(input int unsigned count);
    logic src_bursty;
    src_bursty = 1'b0;
    for (int unsigned i = 0; i < count; i++) begin
      if (i % 50 == 0) begin
        // One early segment runs with no idling at all.
        src_bursty  = (i / 50 != 1) && ($urandom_range(0, 3) != 0);
        sink_bursty <= (i / 50 != 1) && ($urandom_range(0, 3) != 0);
      end
      send_instr(rand_instr());
      if (src_bursty && $urandom_range(0, 2) == 0) idle_source(gap_len());
    end
    wait_all_results();
  endtask

  // The output holds off for a long stretch while records keep coming, so the block
  // fills and stalls its input.
  task automatic test_output_hold(input int unsigned count);
    sink_bursty <= 1'b0;
    hold_token  <= hold_token + 1;
    for (int unsigned i = 0; i < count; i++) begin
      send_instr(rand_instr());
    end
    wait_all_results();
  endtask

  // Short groups, each followed by a full drain of the block.
  task automatic test_drain_pause(input int unsigned rounds);
    int unsigned group;
    sink_bursty <= 1'b1;
    for (int unsigned r = 0; r < rounds; r++) begin
      group = $urandom_range(1, 6);
      for (int unsigned i = 0; i < group; i++) begin
        send_instr(rand_instr());
      end
      wait_all_results();
    end
  endtask

  initial begin
    int unsigned codes_hit;
    int unsigned unknown_hit;
    for (int i = 0; i < 64; i++) opcode_seen[i] = 0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random_mix(1050);
    test_output_hold(40);
    test_drain_pause(15);

    repeat (DRAIN_SLACK) @(posedge clk_i);
    if (pending_words.size() != 0) begin
      report_mismatch("words never delivered", '0, 32'(pending_words.size()));
    end

    codes_hit   = 0;
    unknown_hit = 0;
    for (int i = 0; i < 64; i++) begin
      if (i <= OP_DATA && opcode_seen[i] != 0) codes_hit++;
      if (i > OP_DATA) unknown_hit += opcode_seen[i];
    end
    $display("Checked %0d words: %0d of %0d operation codes, %0d unknown-code records.",
             result_count, codes_hit, OP_DATA + 1, unknown_hit);
    $display("Input stalled on %0d cycles, output held off on %0d cycles.", in_stalls,
             out_stalls);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
